FILE: sv/pips_pkg.sv
// ----------------------------------------------------------------------------
// pips_pkg
// Types, constants and helper functions for the promoter/inhibitor phenology
// step core.
// ----------------------------------------------------------------------------
`default_nettype none

package pips_pkg;

  localparam int FracBits = 16;
  localparam int LvlW     = 20;
  localparam int OpW      = 26;
  localparam int SumW     = 28;
  localparam int DayW     = 9;
  localparam int DivSteps = 17;
  localparam int MulSteps = 9;

  localparam logic [2:0] RegVariant  = 3'd0;
  localparam logic [2:0] RegInhGains = 3'd1;
  localparam logic [2:0] RegProGains = 3'd2;
  localparam logic [2:0] RegInhWin   = 3'd3;
  localparam logic [2:0] RegProWin   = 3'd4;
  localparam logic [2:0] RegStartDay = 3'd5;
  localparam logic [2:0] RegPriorLen = 3'd6;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [15:0]        day_fraction;
    logic               season_start;
  } in_item_t;

  typedef struct packed {
    logic                    reached;
    logic [DayW-1:0]         burst_day;
    logic signed [LvlW-1:0]  promoter_level;
    logic signed [LvlW-1:0]  inhibitor_level;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_A2_RI   = 4'd0,
    MUL_X_I     = 4'd1,
    MUL_INH_F   = 4'd2,
    MUL_A3_RP   = 4'd3,
    MUL_Y_ONEMI = 4'd4,
    MUL_BASE_F  = 4'd5,
    MUL_A4_P    = 4'd6,
    MUL_Z_N     = 4'd7,
    MUL_A1_N    = 4'd8
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     update;
  } dp_cmd_t;

  typedef struct packed {
    logic        zero;
    logic [16:0] x;
    logic [16:0] span;
  } resp_init_t;

  function automatic resp_init_t resp_setup(input logic [47:0] win,
                                            input logic signed [15:0] t);
    logic signed [16:0] lo;
    logic signed [16:0] op;
    logic signed [16:0] hi;
    logic signed [16:0] tt;
    resp_init_t r;
    lo = {win[15], win[15:0]};
    op = {win[31], win[31:16]};
    hi = {win[47], win[47:32]};
    tt = {t[15], t};
    r.zero = 1'b1;
    r.x    = '0;
    r.span = '1;
    if (lo <= tt && tt <= op) begin
      r.x    = 17'(tt - lo);
      r.span = 17'(op - lo);
      r.zero = (op == lo);
    end else if (op < tt && tt <= hi) begin
      r.x    = 17'(hi - tt);
      r.span = 17'(hi - op);
      r.zero = (hi == op);
    end
    if (tt < lo || tt > hi) begin
      r.zero = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [LvlW-1:0] sat_lvl(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi_lim;
    logic signed [SumW-1:0] lo_lim;
    hi_lim = SumW'(524287);
    lo_lim = -SumW'(524288);
    if (v > hi_lim) begin
      return LvlW'(524287);
    end else if (v < lo_lim) begin
      return LvlW'(-524288);
    end
    return v[LvlW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pips_dpath.sv
// ----------------------------------------------------------------------------
// pips_dpath
// Datapath: configuration registers, season state, two bit-serial response
// dividers, one shared multiplier and the level update.
// ----------------------------------------------------------------------------
`default_nettype none

module pips_dpath #(
  parameter int SEASON_DAYS = 365
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [47:0]       cfg_data_i,
  input  wire pips_pkg::in_item_t  in_data_i,
  input  wire pips_pkg::dp_cmd_t   cmd_i,
  output pips_pkg::out_item_t      out_data_o
);

  localparam int OpW  = pips_pkg::OpW;
  localparam int SumW = pips_pkg::SumW;
  localparam int LvlW = pips_pkg::LvlW;
  localparam int DayW = pips_pkg::DayW;

  logic [3:0]  variant_q;
  logic [31:0] inh_gains_q, pro_gains_q;
  logic [47:0] inh_win_q, pro_win_q;
  logic [DayW-1:0] start_day_q, prior_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q   <= 4'd1;
      inh_gains_q <= '0;
      pro_gains_q <= '0;
      inh_win_q   <= '0;
      pro_win_q   <= '0;
      start_day_q <= DayW'(1);
      prior_len_q <= DayW'(365);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pips_pkg::RegVariant:  variant_q   <= cfg_data_i[3:0];
        pips_pkg::RegInhGains: inh_gains_q <= cfg_data_i[31:0];
        pips_pkg::RegProGains: pro_gains_q <= cfg_data_i[31:0];
        pips_pkg::RegInhWin:   inh_win_q   <= cfg_data_i;
        pips_pkg::RegProWin:   pro_win_q   <= cfg_data_i;
        pips_pkg::RegStartDay: start_day_q <= cfg_data_i[DayW-1:0];
        pips_pkg::RegPriorLen: prior_len_q <= cfg_data_i[DayW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [LvlW-1:0] inh_q, pro_q;
  logic [DayW-1:0] cur_day_q, days_q, found_day_q;
  logic found_q;
  logic [15:0] f_q;

  logic [17:0] rem_i_q, rem_p_q;
  logic [16:0] span_i_q, span_p_q, q_i_q, q_p_q;
  logic zero_i_q, zero_p_q;
  pips_pkg::resp_init_t ri_init, rp_init;

  assign ri_init = pips_pkg::resp_setup(inh_win_q, in_data_i.temperature);
  assign rp_init = pips_pkg::resp_setup(pro_win_q, in_data_i.temperature);

  logic ge_i, ge_p;
  logic [16:0] sub_i, sub_p;
  assign ge_i  = rem_i_q >= {1'b0, span_i_q};
  assign ge_p  = rem_p_q >= {1'b0, span_p_q};
  assign sub_i = 17'(rem_i_q - {1'b0, span_i_q});
  assign sub_p = 17'(rem_p_q - {1'b0, span_p_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q      <= in_data_i.day_fraction;
      rem_i_q  <= {1'b0, ri_init.x};
      rem_p_q  <= {1'b0, rp_init.x};
      span_i_q <= ri_init.span;
      span_p_q <= rp_init.span;
      zero_i_q <= ri_init.zero;
      zero_p_q <= rp_init.zero;
      q_i_q    <= '0;
      q_p_q    <= '0;
    end else if (cmd_i.div_step) begin
      q_i_q   <= {q_i_q[15:0], ge_i};
      q_p_q   <= {q_p_q[15:0], ge_p};
      rem_i_q <= ge_i ? {sub_i, 1'b0} : {rem_i_q[16:0], 1'b0};
      rem_p_q <= ge_p ? {sub_p, 1'b0} : {rem_p_q[16:0], 1'b0};
    end
  end

  logic signed [OpW-1:0] x_q, inh_m_q, inhf_q, y_q, base_q, bf_q, z_q, zn_q, an_q;
  logic signed [OpW-1:0] opa, opb, mres;
  logic signed [2*OpW-1:0] prod;
  logic signed [OpW-1:0] a1, a2, a3, a4, r_i, r_p, i0, p0, f_ext, n_ext, onemi;

  assign a1    = OpW'({inh_gains_q[15:0], 4'b0});
  assign a2    = OpW'({inh_gains_q[31:16], 4'b0});
  assign a3    = OpW'({pro_gains_q[15:0], 4'b0});
  assign a4    = OpW'({pro_gains_q[31:16], 4'b0});
  assign r_i   = zero_i_q ? '0 : OpW'(q_i_q);
  assign r_p   = zero_p_q ? '0 : OpW'(q_p_q);
  assign i0    = OpW'(inh_q);
  assign p0    = OpW'(pro_q);
  assign f_ext = OpW'(f_q);
  assign n_ext = OpW'(17'h10000 - {1'b0, f_q});
  assign onemi = OpW'(26'sh10000) - i0;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_sel)
      pips_pkg::MUL_A2_RI:   begin opa = a2;      opb = r_i;   end
      pips_pkg::MUL_X_I:     begin opa = x_q;     opb = i0;    end
      pips_pkg::MUL_INH_F:   begin opa = inh_m_q; opb = f_ext; end
      pips_pkg::MUL_A3_RP:   begin opa = a3;      opb = r_p;   end
      pips_pkg::MUL_Y_ONEMI: begin opa = y_q;     opb = onemi; end
      pips_pkg::MUL_BASE_F:  begin opa = base_q;  opb = f_ext; end
      pips_pkg::MUL_A4_P:    begin opa = a4;      opb = p0;    end
      pips_pkg::MUL_Z_N:     begin opa = z_q;     opb = n_ext; end
      pips_pkg::MUL_A1_N:    begin opa = a1;      opb = n_ext; end
      default: ;
    endcase
  end

  assign prod = opa * opb;
  assign mres = prod[OpW+pips_pkg::FracBits-1:pips_pkg::FracBits];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        pips_pkg::MUL_A2_RI:   x_q     <= mres;
        pips_pkg::MUL_X_I:     inh_m_q <= mres;
        pips_pkg::MUL_INH_F:   inhf_q  <= mres;
        pips_pkg::MUL_A3_RP:   y_q     <= mres;
        pips_pkg::MUL_Y_ONEMI: base_q  <= mres;
        pips_pkg::MUL_BASE_F:  bf_q    <= mres;
        pips_pkg::MUL_A4_P:    z_q     <= mres;
        pips_pkg::MUL_Z_N:     zn_q    <= mres;
        pips_pkg::MUL_A1_N:    an_q    <= mres;
        default: ;
      endcase
    end
  end

  logic signed [SumW-1:0] di, dp, inh_sum, pro_sum;
  logic signed [LvlW-1:0] inh_new, pro_new;
  logic active, burst;
  logic [DayW-1:0] day_inc;

  always_comb begin
    di = '0;
    dp = '0;
    unique case (variant_q)
      4'd1, 4'd2, 4'd4, 4'd5:   di = -SumW'(inh_m_q);
      4'd3, 4'd6:               di = SumW'(an_q) - SumW'(inh_m_q);
      4'd7, 4'd8, 4'd10, 4'd11: di = -SumW'(inhf_q);
      4'd9, 4'd12:              di = SumW'(an_q) - SumW'(inhf_q);
      default:                  di = '0;
    endcase
    unique case (variant_q)
      4'd3, 4'd9:  dp = SumW'(base_q);
      4'd1, 4'd7:  dp = SumW'(base_q) - SumW'(z_q);
      4'd4, 4'd10: dp = SumW'(bf_q) - SumW'(z_q);
      4'd2, 4'd8:  dp = SumW'(base_q) - SumW'(zn_q);
      4'd5, 4'd11: dp = SumW'(bf_q) - SumW'(zn_q);
      4'd6, 4'd12: dp = SumW'(bf_q);
      default:     dp = '0;
    endcase
  end

  assign inh_sum = SumW'(inh_q) + di;
  assign pro_sum = SumW'(pro_q) + dp;
  assign inh_new = pips_pkg::sat_lvl(inh_sum);
  assign pro_new = pips_pkg::sat_lvl(pro_sum);
  assign active  = !found_q && (days_q < DayW'(SEASON_DAYS));
  assign burst   = pro_new >= LvlW'(32'sh10000);
  assign day_inc = cur_day_q + DayW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inh_q       <= LvlW'(32'sh10000);
      pro_q       <= '0;
      cur_day_q   <= DayW'(1);
      days_q      <= '0;
      found_q     <= 1'b0;
      found_day_q <= '0;
    end else if (cmd_i.load && in_data_i.season_start) begin
      inh_q       <= LvlW'(32'sh10000);
      pro_q       <= '0;
      cur_day_q   <= start_day_q;
      days_q      <= '0;
      found_q     <= 1'b0;
      found_day_q <= '0;
    end else if (cmd_i.update && active) begin
      inh_q  <= inh_new;
      pro_q  <= pro_new;
      days_q <= days_q + DayW'(1);
      if (burst) begin
        found_q     <= 1'b1;
        found_day_q <= cur_day_q;
      end else begin
        cur_day_q <= (day_inc > prior_len_q) ? DayW'(1) : day_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (active) begin
        out_data_o.reached         <= burst;
        out_data_o.burst_day       <= burst ? cur_day_q : '0;
        out_data_o.promoter_level  <= pro_new;
        out_data_o.inhibitor_level <= inh_new;
      end else begin
        out_data_o.reached         <= found_q;
        out_data_o.burst_day       <= found_q ? found_day_q : '0;
        out_data_o.promoter_level  <= pro_q;
        out_data_o.inhibitor_level <= inh_q;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/pips_ctrl.sv
// ----------------------------------------------------------------------------
// pips_ctrl
// Controller: sequences load, division steps, multiplications and the
// update, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module pips_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output pips_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic accept, slot_free;

  assign in_stall_o  = state_q != ST_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o.load     = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.mul_sel  = pips_pkg::mul_sel_e'(cnt_q[3:0]);
    cmd_o.update   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(pips_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == 5'(pips_pkg::MulSteps - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (slot_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/promoter_inhibitor_phenology_step_core.sv
// ----------------------------------------------------------------------------
// promoter_inhibitor_phenology_step_core
// One simulated day per input transfer: triangular temperature responses,
// inhibitor and promoter update, and burst day tracking.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data_i (temperature, day fraction, start)
//   out     | output    | out_valid/out_stall| out_data_o (reached, day, levels)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// An item passes through one load, 17 steps of the bit-serial response
// dividers, 9 steps of the shared multiplier and one update.
// A new item is taken once the previous one has reached the output register.
// The result waits in the output register while out_stall_i is high.
// Reset restores the configuration registers, the controller and the season state.
// ----------------------------------------------------------------------------
`default_nettype none

module promoter_inhibitor_phenology_step_core #(
  parameter int SEASON_DAYS = 365
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pips_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pips_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [47:0]          cfg_data_i
);

  pips_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  pips_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pips_dpath #(
    .SEASON_DAYS (SEASON_DAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: verif/tb_promoter_inhibitor_phenology_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_promoter_inhibitor_phenology_step_core
// Self-checking bench for the phenology step core. A bit-accurate predictor
// of the inhibitor and promoter update feeds a scoreboard of expected day
// results. Each result transfer is checked field by field against the oldest
// expected result. The run covers several register settings and idle phases.
// ----------------------------------------------------------------------------

module tb_promoter_inhibitor_phenology_step_core;

  localparam int  SeasonLen = 365;
  localparam longint OneFx  = 65536;
  localparam longint LvlMax = 524287;
  localparam longint LvlMin = -524288;
  localparam longint CycleLimit = 3000000;
  localparam logic [2:0] RegUnused = 3'd7;

  class day_scoreboard;
    logic [3:0]  variant;
    logic [31:0] inh_gains;
    logic [31:0] pro_gains;
    logic [47:0] inh_win;
    logic [47:0] pro_win;
    logic [8:0]  first_day;
    logic [8:0]  year_len;
    longint      inh_lvl;
    longint      pro_lvl;
    int unsigned day_of_year;
    int unsigned days_done;
    bit          burst_seen;
    int unsigned burst_at;
    pips_pkg::out_item_t pending[$];
    int          mismatches;
    int          checked;

    function void restart_season();
      inh_lvl     = OneFx;
      pro_lvl     = 0;
      day_of_year = first_day;
      days_done   = 0;
      burst_seen  = 0;
      burst_at    = 0;
    endfunction

    function void reset_all();
      variant   = 4'd1;
      inh_gains = '0;
      pro_gains = '0;
      inh_win   = '0;
      pro_win   = '0;
      first_day = 9'd1;
      year_len  = 9'd365;
      restart_season();
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        pips_pkg::RegVariant:  variant   = val[3:0];
        pips_pkg::RegInhGains: inh_gains = val[31:0];
        pips_pkg::RegProGains: pro_gains = val[31:0];
        pips_pkg::RegInhWin:   inh_win   = val;
        pips_pkg::RegProWin:   pro_win   = val;
        pips_pkg::RegStartDay: first_day = val[8:0];
        pips_pkg::RegPriorLen: year_len  = val[8:0];
        default: ;
      endcase
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> 16;
    endfunction

    function longint clamp(longint v);
      if (v > LvlMax) return LvlMax;
      if (v < LvlMin) return LvlMin;
      return v;
    endfunction

    function longint gain(logic [31:0] r, int half);
      logic [15:0] g;
      g = half ? r[31:16] : r[15:0];
      return longint'(g) << 4;
    endfunction

    function longint resp(logic [47:0] w, longint t);
      longint lo, op, hi, r;
      lo = longint'($signed(w[15:0]));
      op = longint'($signed(w[31:16]));
      hi = longint'($signed(w[47:32]));
      r = 0;
      if (lo <= t && t <= op && op > lo) r = ((t - lo) << 16) / (op - lo);
      if (op < t && t <= hi && hi > op) r = ((hi - t) << 16) / (hi - op);
      if (t < lo || t > hi) r = 0;
      return r;
    endfunction

    function void note_day(pips_pkg::in_item_t d);
      longint t, f, n, a1, a2, a3, a4, ri, rp, i0, p0, inh, base, di, dp;
      pips_pkg::out_item_t e;
      t = longint'(d.temperature);
      if (d.season_start) restart_season();
      if (!burst_seen && days_done < SeasonLen) begin
        f  = longint'(d.day_fraction);
        n  = OneFx - f;
        a1 = gain(inh_gains, 0);
        a2 = gain(inh_gains, 1);
        a3 = gain(pro_gains, 0);
        a4 = gain(pro_gains, 1);
        ri = resp(inh_win, t);
        rp = resp(pro_win, t);
        i0 = inh_lvl;
        p0 = pro_lvl;
        inh  = fmul(fmul(a2, ri), i0);
        base = fmul(fmul(a3, rp), OneFx - i0);
        di = 0;
        dp = 0;
        case (variant)
          1, 2, 4, 5:   di = -inh;
          3, 6:         di = fmul(a1, n) - inh;
          7, 8, 10, 11: di = -fmul(inh, f);
          9, 12:        di = fmul(a1, n) - fmul(inh, f);
          default: ;
        endcase
        case (variant)
          3, 9:   dp = base;
          1, 7:   dp = base - fmul(a4, p0);
          4, 10:  dp = fmul(base, f) - fmul(a4, p0);
          2, 8:   dp = base - fmul(fmul(a4, p0), n);
          5, 11:  dp = fmul(base, f) - fmul(fmul(a4, p0), n);
          6, 12:  dp = fmul(base, f);
          default: ;
        endcase
        inh_lvl = clamp(i0 + di);
        pro_lvl = clamp(p0 + dp);
        days_done++;
        if (pro_lvl >= OneFx) begin
          burst_seen = 1;
          burst_at = day_of_year & 9'h1ff;
        end else begin
          day_of_year = (day_of_year + 1) & 9'h1ff;
          if (day_of_year > year_len) day_of_year = 1;
        end
      end
      e.reached         = burst_seen;
      e.burst_day       = burst_seen ? 9'(burst_at) : '0;
      e.promoter_level  = pro_lvl[19:0];
      e.inhibitor_level = inh_lvl[19:0];
      pending.push_back(e);
    endfunction

    function void check_day(pips_pkg::out_item_t got);
      pips_pkg::out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.reached !== e.reached || got.burst_day !== e.burst_day ||
          got.promoter_level !== e.promoter_level ||
          got.inhibitor_level !== e.inhibitor_level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected %p, actual %p", e, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pips_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_stall;
  pips_pkg::out_item_t out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  day_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  longint      cycles;
  int          sent;

  promoter_inhibitor_phenology_step_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_day(out_data);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_day(pips_pkg::in_item_t d);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_day(d);
    sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_temp(logic [47:0] w);
    int lo, hi;
    if ($urandom_range(9) == 0) return 16'($urandom);
    lo = $signed(w[15:0]);
    hi = $signed(w[47:32]);
    if (hi < lo) return 16'($urandom);
    return 16'($urandom_range(hi - lo + 40) + lo - 20);
  endfunction

  function automatic logic [47:0] rand_window();
    int lo, op, hi;
    lo = $urandom_range(2000) - 1000;
    op = lo + $urandom_range(3000);
    hi = op + $urandom_range(3000);
    if ($urandom_range(7) == 0) op = lo;
    if ($urandom_range(7) == 0) hi = op;
    return {16'(hi), 16'(op), 16'(lo)};
  endfunction

  task automatic run_phase(int items);
    pips_pkg::in_item_t d;
    for (int k = 0; k < items; k++) begin
      d.temperature  = rand_temp(sb.pro_win);
      d.day_fraction = 16'($urandom);
      d.season_start = ($urandom_range(59) == 0);
      send_day(d);
    end
  endtask

  task automatic random_config();
    write_cfg(pips_pkg::RegVariant, 48'($urandom_range(12, 1)));
    write_cfg(pips_pkg::RegInhGains, 48'($urandom & 32'h1fff_1fff));
    write_cfg(pips_pkg::RegProGains, 48'($urandom & 32'h3fff_1fff));
    write_cfg(pips_pkg::RegInhWin, rand_window());
    write_cfg(pips_pkg::RegProWin, rand_window());
    write_cfg(pips_pkg::RegStartDay, 48'($urandom_range(366, 1)));
    write_cfg(pips_pkg::RegPriorLen, 48'($urandom_range(366, 365)));
  endtask

  initial begin
    pips_pkg::in_item_t d;
    sb = new();
    sb.reset_all();
    cycles = 0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = pips_pkg::RegVariant;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed days: field extremes, zero spans, bad variants, season starts.
    write_cfg(pips_pkg::RegInhWin, {16'sd2560, 16'sd1280, 16'sd0});
    write_cfg(pips_pkg::RegProWin, {16'sd1280, 16'sd1280, -16'sd256});
    write_cfg(pips_pkg::RegInhGains, 48'hffff_ffff);
    write_cfg(pips_pkg::RegProGains, 48'h0000_ffff);
    for (int v = 0; v < 16; v++) begin
      drain();
      write_cfg(pips_pkg::RegVariant, 48'(v));
      d.temperature  = (v % 3 == 0) ? 16'sh7fff : ((v % 3 == 1) ? 16'sh8000 : 16'sd640);
      d.day_fraction = (v & 1) ? 16'hffff : 16'h0000;
      d.season_start = 1'b1;
      send_day(d);
      d.temperature  = 16'sd1280;
      d.season_start = 1'b0;
      send_day(d);
    end
    drain();
    write_cfg(pips_pkg::RegStartDay, 48'd0);
    write_cfg(pips_pkg::RegPriorLen, 48'd511);
    write_cfg(RegUnused, 48'hdead);
    d = '{temperature: 16'sd1280, day_fraction: 16'h8000, season_start: 1'b1};
    send_day(d);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      drain();
      random_config();
      if (ph == 7) begin
        write_cfg(pips_pkg::RegStartDay, 48'd366);
        write_cfg(pips_pkg::RegPriorLen, 48'd366);
      end
      run_phase(150);
    end
    recv_stall_pct = 0;
    drain();

    $display("Sent %0d days over all twelve variants and eight idle phases;", sent);
    $display("checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
